@@ hw/rtl/scfp_pkg.sv @@
// ----------------------------------------------------------------------------
// scfp_pkg
// Shared types and constants of the checksummed response-frame parser.
// ----------------------------------------------------------------------------
package scfp_pkg;

   localparam int BYTE_W      = 8;
   localparam int LEN_W       = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [BYTE_W-1:0] HDR0 = 8'h53;
   localparam logic [BYTE_W-1:0] HDR1 = 8'h59;

   localparam logic [CSR_INDEX_W-1:0] CSR_CONTROL = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMMAND = 1'b1;

   typedef enum logic [3:0] {
      PH_HUNT  = 4'd0,
      PH_HEAD  = 4'd1,
      PH_CTRL  = 4'd2,
      PH_CMD   = 4'd3,
      PH_LENH  = 4'd4,
      PH_LENL  = 4'd5,
      PH_DATA  = 4'd6,
      PH_SUM   = 4'd7,
      PH_TAIL1 = 4'd8,
      PH_TAIL2 = 4'd9
   } phase_type;

   typedef enum logic [1:0] {
      EV_PAYLOAD  = 2'd0,
      EV_COMPLETE = 2'd1,
      EV_MISMATCH = 2'd2
   } event_type;

   typedef struct packed {
      logic [BYTE_W-1:0] control;
      logic [BYTE_W-1:0] command;
   } cfg_type;

   typedef struct packed {
      event_type         event_res;
      logic [BYTE_W-1:0] data_byte;
      logic [LEN_W-1:0]  byte_index;
      logic [LEN_W-1:0]  frame_length;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic    valid;
      rsp_type data;
   } result_type;

endpackage

@@ hw/rtl/scfp_req_if.sv @@
// ----------------------------------------------------------------------------
// scfp_req_if
// Received-byte channel: one serial byte per item.
// ----------------------------------------------------------------------------
interface scfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/scfp_rsp_if.sv @@
// ----------------------------------------------------------------------------
// scfp_rsp_if
// Parser event channel: payload bytes, frame completion, checksum mismatch.
// ----------------------------------------------------------------------------
interface scfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_res;
   logic [7:0]  data_byte;
   logic [15:0] byte_index;
   logic [15:0] frame_length;
   logic        last;

   modport source (output valid, output event_res, output data_byte, output byte_index,
                   output frame_length, output last, input ready);
   modport sink   (input valid, input event_res, input data_byte, input byte_index,
                   input frame_length, input last, output ready);
endinterface

@@ hw/rtl/scfp_parser.sv @@
// ----------------------------------------------------------------------------
// scfp_parser
// Frame state machine: tracks header, control, command, length, payload,
// checksum and tail; produces at most one result per accepted byte.
// ----------------------------------------------------------------------------
module scfp_parser (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step,
   input  logic [7:0]                 rx_byte,
   input  scfp_pkg::cfg_type          cfg,
   output scfp_pkg::result_type       result
);
   import scfp_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [LEN_W-1:0]  length_ff, length_in;
   logic [LEN_W-1:0]  count_ff, count_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [LEN_W-1:0]  count_next;
   logic [LEN_W-1:0]  length_low;

   assign count_next = count_ff + LEN_W'(1);
   assign length_low = {length_ff[LEN_W-1:BYTE_W], rx_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
      length_ff <= length_in;
      count_ff  <= count_in;
      sum_ff    <= sum_in;
   end

   always_comb begin
      phase_in                 = phase_ff;
      length_in                = length_ff;
      count_in                 = count_ff;
      sum_in                   = sum_ff;
      result.valid             = 1'b0;
      result.data.event_res    = EV_PAYLOAD;
      result.data.data_byte    = rx_byte;
      result.data.byte_index   = '0;
      result.data.frame_length = length_ff;
      result.data.last         = 1'b0;
      if (step) begin
         case (phase_ff)
            PH_HEAD: begin
               if (rx_byte == HDR1) begin
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_CTRL;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CTRL: begin
               if (rx_byte == cfg.control) begin
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_CMD;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_CMD: begin
               if (rx_byte == cfg.command) begin
                  sum_in   = sum_ff + rx_byte;
                  phase_in = PH_LENH;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_LENH: begin
               sum_in    = sum_ff + rx_byte;
               length_in = {rx_byte, {BYTE_W{1'b0}}};
               phase_in  = PH_LENL;
            end
            PH_LENL: begin
               sum_in    = sum_ff + rx_byte;
               length_in = length_low;
               count_in  = '0;
               phase_in  = (length_low == '0) ? PH_SUM : PH_DATA;
            end
            PH_DATA: begin
               sum_in                 = sum_ff + rx_byte;
               count_in               = count_next;
               if (count_next == length_ff) begin
                  phase_in = PH_SUM;
               end
               result.valid           = 1'b1;
               result.data.byte_index = count_ff;
            end
            PH_SUM: begin
               if (rx_byte == sum_ff) begin
                  phase_in = PH_TAIL1;
               end else begin
                  phase_in              = PH_HUNT;
                  result.valid          = 1'b1;
                  result.data.event_res = EV_MISMATCH;
                  result.data.last      = 1'b1;
               end
            end
            PH_TAIL1: begin
               phase_in = PH_TAIL2;
            end
            PH_TAIL2: begin
               phase_in              = PH_HUNT;
               result.valid          = 1'b1;
               result.data.event_res = EV_COMPLETE;
               result.data.last      = 1'b1;
            end
            default: begin
               if (rx_byte == HDR0) begin
                  sum_in   = HDR0;
                  count_in = '0;
                  phase_in = PH_HEAD;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

endmodule

@@ hw/rtl/sum_checked_frame_parser.sv @@
// ----------------------------------------------------------------------------
// sum_checked_frame_parser
// Parses 0x53 0x59 response frames from a received byte stream, checks the
// control/command bytes and the 8-bit additive checksum, and reports events.
// ----------------------------------------------------------------------------
//   channel   dir  handshake     payload
//   req_chan  in   valid/ready   rx_byte
//   rsp_chan  out  valid/ready   event_res, data_byte, byte_index,
//                                frame_length, last
//   csr_*     in   csr_we        csr_index, csr_wdata
//
// One item per cycle while the output is not stalled; the result of an item shows
// in the cycle after accept, from the output register.
// Input ready drops only while a result sits unaccepted in that register.
// Reset (synchronous) clears the parser phase, output valid and both
// configuration registers.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser (
   input  logic                                 clock,
   input  logic                                 reset,
   scfp_req_if.sink                             req_chan,
   scfp_rsp_if.source                           rsp_chan,
   input  logic                                 csr_we,
   input  logic [scfp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [scfp_pkg::BYTE_W-1:0]          csr_wdata
);
   import scfp_pkg::*;

   cfg_type    cfg_ff, cfg_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_ff, rsp_in;
   result_type result;
   logic       req_ready;
   logic       req_accept;

   assign req_ready      = !rsp_valid_ff || rsp_chan.ready;
   assign req_accept     = req_chan.valid && req_ready;
   assign req_chan.ready = req_ready;

   scfp_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (req_accept),
      .rx_byte (req_chan.rx_byte),
      .cfg     (cfg_ff),
      .result  (result)
   );

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_CONTROL: cfg_in.control = csr_wdata;
            CSR_COMMAND: cfg_in.command = csr_wdata;
            default:     cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (req_ready) begin
         rsp_valid_in = req_accept && result.valid;
         if (req_accept && result.valid) begin
            rsp_in = result.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff       <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.event_res    = rsp_ff.event_res;
   assign rsp_chan.data_byte    = rsp_ff.data_byte;
   assign rsp_chan.byte_index   = rsp_ff.byte_index;
   assign rsp_chan.frame_length = rsp_ff.frame_length;
   assign rsp_chan.last         = rsp_ff.last;

`ifndef SYNTHESIS
   a_stall_blocks_input : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("input taken while result stalled");

   a_index_in_range : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.event_res == EV_PAYLOAD) |->
         (rsp_ff.byte_index < rsp_ff.frame_length))
      else $error("payload index beyond frame length");

   a_last_on_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_ff.last == (rsp_ff.event_res != EV_PAYLOAD)))
      else $error("last flag does not match event");

   a_reset_clears : assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid after reset");
`endif

endmodule

@@ sim/sum_checked_frame_parser_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sum_checked_frame_parser_tb
// Feeds received bytes to the frame parser: directed corner frames first, then
// random frames, broken headers, bad checksums and line noise under several
// stall patterns and control/command settings. A local frame tracker predicts
// every event and each accepted event is compared field by field.
// ----------------------------------------------------------------------------
module sum_checked_frame_parser_tb;
   import scfp_pkg::*;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [BYTE_W-1:0]      csr_wdata;

   scfp_req_if req_if ();
   scfp_rsp_if rsp_if ();

   sum_checked_frame_parser u_top (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_if),
      .rsp_chan  (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   logic [7:0] rx_pending[$];
   rsp_type    awaited_events[$];
   rsp_type    got_event;
   cfg_type    frame_cfg;

   phase_type   trk_phase;
   logic [15:0] trk_len;
   logic [15:0] trk_count;
   logic [7:0]  trk_sum;

   bit          req_taken;
   int unsigned send_idle_pct;
   int unsigned recv_stall_pct;
   int unsigned phase_items;
   int unsigned fail_count;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("FAILURE");
      $finish;
   end

   // frame tracker: one received byte in, zero or one event out
   task automatic parse_byte(input logic [7:0] b);
      rsp_type ev;
      ev.event_res    = EV_PAYLOAD;
      ev.data_byte    = b;
      ev.byte_index   = '0;
      ev.frame_length = trk_len;
      ev.last         = 1'b1;
      case (trk_phase)
         PH_HEAD: begin
            if (b == HDR1) begin
               trk_sum   = trk_sum + b;
               trk_phase = PH_CTRL;
            end else begin
               trk_phase = PH_HUNT;
            end
         end
         PH_CTRL: begin
            if (b == frame_cfg.control) begin
               trk_sum   = trk_sum + b;
               trk_phase = PH_CMD;
            end else begin
               trk_phase = PH_HUNT;
            end
         end
         PH_CMD: begin
            if (b == frame_cfg.command) begin
               trk_sum   = trk_sum + b;
               trk_phase = PH_LENH;
            end else begin
               trk_phase = PH_HUNT;
            end
         end
         PH_LENH: begin
            trk_sum   = trk_sum + b;
            trk_len   = {b, 8'h00};
            trk_phase = PH_LENL;
         end
         PH_LENL: begin
            trk_sum      = trk_sum + b;
            trk_len[7:0] = b;
            trk_count    = '0;
            trk_phase    = (trk_len == 16'd0) ? PH_SUM : PH_DATA;
         end
         PH_DATA: begin
            ev.byte_index = trk_count;
            ev.last       = 1'b0;
            awaited_events.push_back(ev);
            trk_sum   = trk_sum + b;
            trk_count = trk_count + 16'd1;
            if (trk_count == trk_len) trk_phase = PH_SUM;
         end
         PH_SUM: begin
            if (b == trk_sum) begin
               trk_phase = PH_TAIL1;
            end else begin
               trk_phase    = PH_HUNT;
               ev.event_res = EV_MISMATCH;
               awaited_events.push_back(ev);
            end
         end
         PH_TAIL1: trk_phase = PH_TAIL2;
         PH_TAIL2: begin
            trk_phase    = PH_HUNT;
            ev.event_res = EV_COMPLETE;
            awaited_events.push_back(ev);
         end
         default: begin
            if (b == HDR0) begin
               trk_sum   = HDR0;
               trk_count = '0;
               trk_phase = PH_HEAD;
            end else begin
               trk_phase = PH_HUNT;
            end
         end
      endcase
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
      end
   endtask

   // driver: new item at the falling edge once the previous one was taken
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_if.valid || req_taken) begin
            if (rx_pending.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
               req_if.valid   <= 1'b1;
               req_if.rx_byte <= rx_pending.pop_front();
            end else begin
               req_if.valid <= 1'b0;
            end
         end
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // monitor: check events first, then predict from the byte taken this edge
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (awaited_events.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: unexpected event %0d, data %h", $realtime,
                           rsp_if.event_res, rsp_if.data_byte);
            end else begin
               got_event = awaited_events.pop_front();
               check_field("event_res", 16'(got_event.event_res), 16'(rsp_if.event_res));
               check_field("data_byte", 16'(got_event.data_byte), 16'(rsp_if.data_byte));
               check_field("byte_index", got_event.byte_index, rsp_if.byte_index);
               check_field("frame_length", got_event.frame_length, rsp_if.frame_length);
               check_field("last", 16'(got_event.last), 16'(rsp_if.last));
            end
         end
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) parse_byte(req_if.rx_byte);
      end
   end

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == CSR_CONTROL) frame_cfg.control = value;
      else frame_cfg.command = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (rx_pending.size() != 0 || req_if.valid || awaited_events.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic add_frame(input logic [15:0] len, input bit good_sum);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] head[6];
      head = '{HDR0, HDR1, frame_cfg.control, frame_cfg.command, len[15:8], len[7:0]};
      sum  = '0;
      foreach (head[i]) begin
         rx_pending.push_back(head[i]);
         sum = sum + head[i];
      end
      for (int i = 0; i < int'(len); i++) begin
         b   = 8'($urandom_range(0, 255));
         rx_pending.push_back(b);
         sum = sum + b;
      end
      if (!good_sum) sum = sum ^ (8'h01 << $urandom_range(0, 7));
      rx_pending.push_back(sum);
      rx_pending.push_back(8'($urandom_range(0, 255)));
      rx_pending.push_back(8'($urandom_range(0, 255)));
      phase_items += 9 + int'(len);
   endtask

   // header, control or command byte wrong; the bad byte is often 0x53
   task automatic add_broken();
      int unsigned stage;
      logic [7:0]  want;
      logic [7:0]  bad;
      stage = $urandom_range(0, 2);
      want  = (stage == 0) ? HDR1 : (stage == 1) ? frame_cfg.control : frame_cfg.command;
      bad   = ($urandom_range(0, 3) == 0) ? HDR0 : 8'($urandom_range(0, 255));
      if (bad == want) bad = ~want;
      rx_pending.push_back(HDR0);
      if (stage >= 1) rx_pending.push_back(HDR1);
      if (stage == 2) rx_pending.push_back(frame_cfg.control);
      rx_pending.push_back(bad);
      phase_items += stage + 2;
   endtask

   initial begin
      int unsigned sel;
      logic [15:0] len;
      logic [7:0]  b;
      logic [7:0]  corner[$];

      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_CONTROL;
      csr_wdata      = '0;
      req_if.valid   = 1'b0;
      req_if.rx_byte = '0;
      rsp_if.ready   = 1'b0;
      req_taken      = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      fail_count     = 0;
      frame_cfg      = '0;
      trk_phase      = PH_HUNT;
      trk_len        = '0;
      trk_count      = '0;
      trk_sum        = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // repeated first header byte, empty frame, bad checksum, wrong control
      corner = '{8'h53, 8'h53, 8'h59, 8'h00,
                 8'h53, 8'h59, 8'h00, 8'h00, 8'h00, 8'h00, 8'hAC, 8'h00, 8'hFF,
                 8'h53, 8'h59, 8'h00, 8'h00, 8'h00, 8'h01, 8'hFF, 8'h00,
                 8'h53, 8'h59, 8'h01};
      foreach (corner[i]) rx_pending.push_back(corner[i]);
      wait_drained();

      for (int ph = 0; ph < 8; ph++) begin
         case (ph % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
            default: begin send_idle_pct = 23; recv_stall_pct = 23; end
         endcase
         case (ph)
            0: begin write_csr(CSR_CONTROL, 8'hFF); write_csr(CSR_COMMAND, 8'h00); end
            1: begin write_csr(CSR_CONTROL, 8'h00); write_csr(CSR_COMMAND, 8'hFF); end
            2: begin write_csr(CSR_CONTROL, 8'hFF); write_csr(CSR_COMMAND, 8'hFF); end
            default: begin
               write_csr(CSR_CONTROL, 8'($urandom_range(0, 255)));
               write_csr(CSR_COMMAND, 8'($urandom_range(0, 255)));
            end
         endcase
         // long frame carries the payload index past one byte
         if (ph == 0) add_frame(16'h01FF, 1'b1);
         phase_items = 0;
         while (phase_items < 190) begin
            sel = $urandom_range(0, 99);
            len = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(13, 300))
                                               : 16'($urandom_range(0, 12));
            if (sel < 65) begin
               add_frame(len, 1'b1);
            end else if (sel < 75) begin
               add_frame(len, 1'b0);
            end else if (sel < 88) begin
               add_broken();
            end else begin
               repeat ($urandom_range(1, 6)) begin
                  b = 8'($urandom_range(0, 255));
                  if (b == HDR0) b = b ^ 8'h01;
                  rx_pending.push_back(b);
               end
            end
         end
         wait_drained();
      end

      if (fail_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hw/rtl/scfp_pkg.sv
hw/rtl/scfp_req_if.sv
hw/rtl/scfp_rsp_if.sv
hw/rtl/scfp_parser.sv
hw/rtl/sum_checked_frame_parser.sv
sim/sum_checked_frame_parser_tb.sv
